// ----- sv/pcu_pkg.sv -----
// Shared types, constants, factorial table and microcode for the permutation/combination unit.
package pcu_pkg;

    // Largest a the factorial table covers; 20! is the last factorial below 2^62.
    localparam int FACT_TOP = 20;
    localparam int MAX_N_DEFAULT = 20;

    // Field widths.
    localparam int ITEM_W = 5;
    localparam int COUNT_W = 62;

    // Sequencer geometry.
    localparam int STEP_W = 3;
    localparam int ITER_W = $clog2(COUNT_W);

    // Error codes reported with each result.
    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_RANGE_A = 2'd1,
        ERR_B_GT_A  = 2'd2
    } err_code_t;

    // Datapath operations selected by the control word.
    typedef enum logic [2:0] {
        OP_NOP       = 3'd0,
        OP_LOAD_REQ  = 3'd1,
        OP_LOAD_DIV1 = 3'd2,
        OP_DIV_STEP  = 3'd3,
        OP_LOAD_DIV2 = 3'd4,
        OP_WRITE     = 3'd5
    } uop_t;

    // Jump conditions.
    typedef enum logic [2:0] {
        COND_NEVER    = 3'd0,
        COND_NO_INPUT = 3'd1,
        COND_ERR      = 3'd2,
        COND_ITER     = 3'd3,
        COND_PERM     = 3'd4,
        COND_OUT_BUSY = 3'd5
    } cond_t;

    // One control word of the microprogram.
    typedef struct packed {
        uop_t              op;
        cond_t             cond;
        logic [STEP_W-1:0] target;
        logic              wrap;
    } ctl_word_t;

    // Control group from the sequencer to the divider.
    typedef struct packed {
        logic load;
        logic step;
    } div_ctl_t;

    // Named microprogram addresses.
    localparam logic [STEP_W-1:0] UA_WAIT   = 3'd0;
    localparam logic [STEP_W-1:0] UA_CHECK  = 3'd1;
    localparam logic [STEP_W-1:0] UA_DIV1   = 3'd2;
    localparam logic [STEP_W-1:0] UA_SETUP2 = 3'd3;
    localparam logic [STEP_W-1:0] UA_DIV2   = 3'd4;
    localparam logic [STEP_W-1:0] UA_WRITE  = 3'd5;

    // Microprogram ROM. A taken jump goes to target; otherwise the step
    // counter advances, or returns to the start when wrap is set.
    function automatic ctl_word_t ucode(input logic [STEP_W-1:0] addr);
        ctl_word_t w;
        begin
            w = '{op: OP_NOP, cond: COND_NEVER, target: UA_WAIT, wrap: 1'b1};
            case (addr)
                UA_WAIT:   w = '{op: OP_LOAD_REQ,  cond: COND_NO_INPUT,
                                 target: UA_WAIT,  wrap: 1'b0};
                UA_CHECK:  w = '{op: OP_LOAD_DIV1, cond: COND_ERR,
                                 target: UA_WRITE, wrap: 1'b0};
                UA_DIV1:   w = '{op: OP_DIV_STEP,  cond: COND_ITER,
                                 target: UA_DIV1,  wrap: 1'b0};
                UA_SETUP2: w = '{op: OP_LOAD_DIV2, cond: COND_PERM,
                                 target: UA_WRITE, wrap: 1'b0};
                UA_DIV2:   w = '{op: OP_DIV_STEP,  cond: COND_ITER,
                                 target: UA_DIV2,  wrap: 1'b0};
                UA_WRITE:  w = '{op: OP_WRITE,     cond: COND_OUT_BUSY,
                                 target: UA_WRITE, wrap: 1'b1};
                default:   w = '{op: OP_NOP,       cond: COND_NEVER,
                                 target: UA_WAIT,  wrap: 1'b1};
            endcase
            return w;
        end
    endfunction

    // Factorial table 0! .. 20!; entries past the table read as one.
    function automatic logic [COUNT_W-1:0] fact(input logic [ITEM_W-1:0] n);
        logic [COUNT_W-1:0] f;
        begin
            case (n)
                5'd0:    f = 62'd1;
                5'd1:    f = 62'd1;
                5'd2:    f = 62'd2;
                5'd3:    f = 62'd6;
                5'd4:    f = 62'd24;
                5'd5:    f = 62'd120;
                5'd6:    f = 62'd720;
                5'd7:    f = 62'd5040;
                5'd8:    f = 62'd40320;
                5'd9:    f = 62'd362880;
                5'd10:   f = 62'd3628800;
                5'd11:   f = 62'd39916800;
                5'd12:   f = 62'd479001600;
                5'd13:   f = 62'd6227020800;
                5'd14:   f = 62'd87178291200;
                5'd15:   f = 62'd1307674368000;
                5'd16:   f = 62'd20922789888000;
                5'd17:   f = 62'd355687428096000;
                5'd18:   f = 62'd6402373705728000;
                5'd19:   f = 62'd121645100408832000;
                5'd20:   f = 62'd2432902008176640000;
                default: f = 62'd1;
            endcase
            return f;
        end
    endfunction

endpackage

// ----- sv/pcu_div.sv -----
// Restoring divider that produces one quotient bit per cycle while step is asserted.
module pcu_div
    import pcu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  div_ctl_t           ctl,
    input  logic [COUNT_W-1:0] dividend,
    input  logic [COUNT_W-1:0] divisor,
    output logic [COUNT_W-1:0] quotient,
    output logic               last
);

    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(COUNT_W - 1);

    logic [COUNT_W-1:0] num_reg, num_next;
    logic [COUNT_W-1:0] den_reg, den_next;
    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic [ITER_W-1:0]  iter_reg, iter_next;
    logic [COUNT_W:0]   rem_shift;
    logic [COUNT_W+1:0] diff;
    logic               borrow;

    // Trial subtraction of the divisor from the shifted partial remainder.
    assign rem_shift = {rem_reg, num_reg[COUNT_W-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, den_reg};
    assign borrow    = diff[COUNT_W+1];

    // Load, iterate or hold. The quotient bits shift into the dividend register.
    always_comb
    begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        iter_next = iter_reg;
        if (ctl.load)
        begin
            num_next  = dividend;
            den_next  = divisor;
            rem_next  = '0;
            iter_next = ITER_LAST;
        end
        else if (ctl.step)
        begin
            num_next = {num_reg[COUNT_W-2:0], ~borrow};
            rem_next = borrow ? rem_shift[COUNT_W-1:0] : diff[COUNT_W-1:0];
            if (iter_reg != '0)
            begin
                iter_next = iter_reg - 1'b1;
            end
        end
    end

    // The iteration counter is control state; operands need no reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg <= '0;
        end
        else
        begin
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign quotient = num_reg;
    assign last     = (iter_reg == '0);

endmodule

// ----- sv/permutation_combination_unit.sv -----
// Top level: microcoded sequencer for exact permutation and combination counts.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+----------------------------------------
//  in      | input     | in_valid/in_stall  | kind, total_items, chosen_items
//  out     | output    | out_valid/out_stall| count_value, error_code
//
// A request with an error goes straight to the write step, a permutation makes one
// division and a combination two, on the shared divider, which makes one
// quotient bit per cycle while it steps: a! by (a-b)! first, then that quotient by b!.
// Reset clears the step counter and the output valid flag.
// The result waits in an output register, so a stalled output holds only the
// final write step; the next request is taken as soon as the program restarts.
module permutation_combination_unit
    import pcu_pkg::*;
#(
    parameter int MAX_N = MAX_N_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               kind,
    input  logic [ITEM_W-1:0]  total_items,
    input  logic [ITEM_W-1:0]  chosen_items,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [COUNT_W-1:0] count_value,
    output logic [1:0]         error_code
);

    // Highest valid a: the parameter, capped at the end of the factorial table.
    localparam logic [ITEM_W-1:0] MAX_A = ITEM_W'((MAX_N < FACT_TOP) ? MAX_N : FACT_TOP);

    logic [STEP_W-1:0]  step_reg, step_next;
    ctl_word_t          uc;
    logic               jump;
    logic               out_busy;
    logic               load_req;
    logic               write_res;

    logic               kind_reg;
    logic [ITEM_W-1:0]  a_reg;
    logic [ITEM_W-1:0]  b_reg;
    err_code_t          err_reg, err_next;

    logic               out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0] count_reg;
    err_code_t          code_reg;

    div_ctl_t           div_ctl;
    logic [COUNT_W-1:0] div_dividend;
    logic [COUNT_W-1:0] div_divisor;
    logic [COUNT_W-1:0] div_quotient;
    logic               div_last;

    // Fetch the control word for the current step.
    assign uc       = ucode(step_reg);
    assign out_busy = out_valid_reg && out_stall;

    // Jump condition selection.
    always_comb
    begin
        case (uc.cond)
            COND_NEVER:    jump = 1'b0;
            COND_NO_INPUT: jump = !in_valid;
            COND_ERR:      jump = (err_reg != ERR_NONE);
            COND_ITER:     jump = !div_last;
            COND_PERM:     jump = !kind_reg;
            COND_OUT_BUSY: jump = out_busy;
            default:       jump = 1'b0;
        endcase
    end

    // Step counter: jump, return to start, or advance.
    always_comb
    begin
        if (jump)
        begin
            step_next = uc.target;
        end
        else if (uc.wrap)
        begin
            step_next = UA_WAIT;
        end
        else
        begin
            step_next = step_reg + 1'b1;
        end
    end

    // Operation strobes qualified by the handshakes.
    assign in_stall  = (uc.op != OP_LOAD_REQ);
    assign load_req  = (uc.op == OP_LOAD_REQ) && in_valid;
    assign write_res = (uc.op == OP_WRITE) && !out_busy;

    // Range checks on the incoming transaction; the a check takes precedence.
    always_comb
    begin
        if (total_items == '0 || total_items > MAX_A)
        begin
            err_next = ERR_RANGE_A;
        end
        else if (chosen_items > total_items)
        begin
            err_next = ERR_B_GT_A;
        end
        else
        begin
            err_next = ERR_NONE;
        end
    end

    // Divider operands: a! / (a-b)! first, then that quotient / b!.
    always_comb
    begin
        div_ctl.load = (uc.op == OP_LOAD_DIV1) || (uc.op == OP_LOAD_DIV2);
        div_ctl.step = (uc.op == OP_DIV_STEP);
        if (uc.op == OP_LOAD_DIV1)
        begin
            div_dividend = fact(a_reg);
            div_divisor  = fact(a_reg - b_reg);
        end
        else
        begin
            div_dividend = div_quotient;
            div_divisor  = fact(b_reg);
        end
    end

    pcu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .last     (div_last)
    );

    // Output valid flag: set by the write step, cleared when taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (write_res)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= UA_WAIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request and result payload registers.
    always_ff @(posedge clk)
    begin
        if (load_req)
        begin
            kind_reg <= kind;
            a_reg    <= total_items;
            b_reg    <= chosen_items;
            err_reg  <= err_next;
        end
        if (write_res)
        begin
            count_reg <= (err_reg == ERR_NONE) ? div_quotient : '0;
            code_reg  <= err_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign count_value = count_reg;
    assign error_code  = code_reg;

endmodule

// ----- verif/pcu_count_checker.sv -----
// Request kinds and the checker that predicts and compares every result of the unit.
package pcu_tb_pkg;

    // Request kinds carried by the kind field.
    localparam logic KIND_PERM = 1'b0;
    localparam logic KIND_COMB = 1'b1;

endpackage

module pcu_count_checker
    import pcu_pkg::*;
    import pcu_tb_pkg::*;
#(
    parameter int MAX_N = MAX_N_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               kind,
    input  logic [ITEM_W-1:0]  total_items,
    input  logic [ITEM_W-1:0]  chosen_items,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [COUNT_W-1:0] count_value,
    input  logic [1:0]         error_code,
    output int                 failures,
    output int                 pending,
    output int                 checked,
    output int                 flagged
);
    timeunit 1ns;
    timeprecision 1ps;

    // One predicted result, together with the request that caused it.
    typedef struct {
        logic               kind;
        logic [ITEM_W-1:0]  a;
        logic [ITEM_W-1:0]  b;
        logic [COUNT_W-1:0] count;
        err_code_t          err;
    } count_expect_t;

    count_expect_t expected_counts[$];

    // Work out the count of b picks out of a, or the reason the request is rejected.
    function automatic count_expect_t count_selections(input logic k,
                                                       input logic [ITEM_W-1:0] a,
                                                       input logic [ITEM_W-1:0] b);
        count_expect_t e;
        logic [63:0]   prod;
        int            ai;
        int            bi;
        int            i;
        begin
            ai = int'(a);
            bi = int'(b);
            e.kind = k;
            e.a = a;
            e.b = b;
            e.count = '0;
            e.err = ERR_NONE;
            if (ai < 1 || ai > MAX_N || ai > FACT_TOP) begin
                e.err = ERR_RANGE_A;
            end
            else if (bi > ai) begin
                e.err = ERR_B_GT_A;
            end
            else begin
                // Ordered picks: a * (a-1) * ... * (a-b+1).
                prod = 64'd1;
                for (i = ai - bi + 1; i <= ai; i++)
                    prod = prod * 64'(i);
                // Unordered picks: divide out b! one factor at a time, exact at every step.
                if (k == KIND_COMB) begin
                    for (i = 2; i <= bi; i++)
                        prod = prod / 64'(i);
                end
                e.count = prod[COUNT_W-1:0];
            end
            return e;
        end
    endfunction

    initial begin
        failures = 0;
        pending = 0;
        checked = 0;
        flagged = 0;
    end

    // Record accepted requests and compare accepted results with the oldest prediction.
    always @(posedge clk) begin
        count_expect_t e;
        if (rst_n) begin
            if (in_valid && !in_stall)
                expected_counts.push_back(count_selections(kind, total_items, chosen_items));
            if (out_valid && !out_stall) begin
                if (expected_counts.size() == 0) begin
                    $display("%0t: unexpected result count_value=%0d error_code=%0d",
                             $time, count_value, error_code);
                    failures++;
                end
                else begin
                    e = expected_counts.pop_front();
                    checked++;
                    if (e.err != ERR_NONE)
                        flagged++;
                    if (count_value !== e.count) begin
                        $display("%0t: count_value mismatch kind=%0d a=%0d b=%0d: expected %0d, got %0d",
                                 $time, e.kind, e.a, e.b, e.count, count_value);
                        failures++;
                    end
                    if (error_code !== e.err) begin
                        $display("%0t: error_code mismatch kind=%0d a=%0d b=%0d: expected %0d, got %0d",
                                 $time, e.kind, e.a, e.b, e.err, error_code);
                        failures++;
                    end
                end
            end
            pending = expected_counts.size();
        end
    end

endmodule

// ----- verif/tb.sv -----
// Testbench top: drives requests into the permutation/combination unit and gives the verdict.
module tb
    import pcu_pkg::*;
    import pcu_tb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 140;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               kind;
    logic [ITEM_W-1:0]  total_items;
    logic [ITEM_W-1:0]  chosen_items;
    logic               out_valid;
    logic               out_stall;
    logic [COUNT_W-1:0] count_value;
    logic [1:0]         error_code;

    int failures;
    int pending;
    int checked;
    int flagged;
    int cycles;
    int perm_sent;
    int comb_sent;

    // Idling switches for the two sides.
    bit sender_gaps;
    bit sink_stalls;

    permutation_combination_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .total_items  (total_items),
        .chosen_items (chosen_items),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .count_value  (count_value),
        .error_code   (error_code)
    );

    pcu_count_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .total_items  (total_items),
        .chosen_items (chosen_items),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .count_value  (count_value),
        .error_code   (error_code),
        .failures     (failures),
        .pending      (pending),
        .checked      (checked),
        .flagged      (flagged)
    );

    // Clock.
    always #5 clk = ~clk;

    // Run limit in case the unit hangs.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side stalls at random when enabled.
    always @(negedge clk)
    begin
        out_stall <= sink_stalls && ($urandom_range(99) < 35);
    end

    // Present one request and hold it until the unit takes it. Entered and left at a falling edge.
    task automatic issue_request(input logic k, input logic [ITEM_W-1:0] a,
                                 input logic [ITEM_W-1:0] b);
        begin
            while (sender_gaps && $urandom_range(99) < 35)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid <= 1'b1;
            kind <= k;
            total_items <= a;
            chosen_items <= b;
            if (k == KIND_COMB)
                comb_sent++;
            else
                perm_sent++;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            @(negedge clk);
        end
    endtask

    // Random requests: mostly well-formed, the rest anything the fields allow.
    task automatic issue_random(input int n);
        logic [ITEM_W-1:0] a;
        logic [ITEM_W-1:0] b;
        int                j;
        begin
            for (j = 0; j < n; j++)
            begin
                if ($urandom_range(99) < 75)
                begin
                    a = ITEM_W'($urandom_range(MAX_N_DEFAULT, 1));
                    b = ITEM_W'($urandom_range(int'(a), 0));
                end
                else
                begin
                    a = ITEM_W'($urandom_range(31, 0));
                    b = ITEM_W'($urandom_range(31, 0));
                end
                issue_request(logic'($urandom_range(1, 0)), a, b);
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = KIND_PERM;
        total_items = '0;
        chosen_items = '0;
        out_stall = 1'b0;
        cycles = 0;
        perm_sent = 0;
        comb_sent = 0;
        sender_gaps = 1'b1;
        sink_stalls = 1'b1;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed requests: range errors on a, b above a, zero picks and the table ends.
        issue_request(KIND_PERM, 5'd0, 5'd0);
        issue_request(KIND_COMB, 5'd0, 5'd31);
        issue_request(KIND_PERM, 5'd21, 5'd3);
        issue_request(KIND_COMB, 5'd31, 5'd31);
        issue_request(KIND_PERM, 5'd5, 5'd6);
        issue_request(KIND_COMB, 5'd20, 5'd31);
        issue_request(KIND_COMB, 5'd1, 5'd2);
        issue_request(KIND_PERM, 5'd1, 5'd0);
        issue_request(KIND_COMB, 5'd1, 5'd0);
        issue_request(KIND_PERM, 5'd1, 5'd1);
        issue_request(KIND_COMB, 5'd1, 5'd1);
        issue_request(KIND_PERM, 5'd20, 5'd0);
        issue_request(KIND_COMB, 5'd20, 5'd0);
        issue_request(KIND_PERM, 5'd20, 5'd20);
        issue_request(KIND_COMB, 5'd20, 5'd20);
        issue_request(KIND_PERM, 5'd20, 5'd1);
        issue_request(KIND_PERM, 5'd20, 5'd10);
        issue_request(KIND_COMB, 5'd20, 5'd10);
        issue_request(KIND_COMB, 5'd19, 5'd9);
        issue_request(KIND_PERM, 5'd10, 5'd5);
        issue_request(KIND_COMB, 5'd15, 5'd7);

        // Random traffic with both sides idling.
        issue_random(150);

        // Let the unit drain completely before the next burst.
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        // Back-to-back stretch with no idling on either side.
        sender_gaps = 1'b0;
        sink_stalls = 1'b0;
        issue_random(100);

        // Idling again for the rest of the run.
        sender_gaps = 1'b1;
        sink_stalls = 1'b1;
        issue_random(250);

        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d permutation and %0d combination requests over %0d cycles.",
                 perm_sent, comb_sent, cycles);
        $display("Compared %0d results, %0d of them rejected requests; %0d mismatches.",
                 checked, flagged, failures);
        if (failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
